[sv/kcu_pkg.sv]
// kcu_pkg: shared widths, constants and status codes for the combination unranker
// no dependencies; imported by every module of the block

package kcu_pkg;

    // built maximum word length (default for the top-level parameter)
    localparam int MAX_LEN_DEF = 32;

    // input field widths
    localparam int CNT_W  = 7;
    localparam int RANK_W = 30;

    // table entry width and saturation cap
    localparam int VAL_W = 30;
    localparam logic [VAL_W-1:0] BINOM_CAP = 30'd1001001001;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;
    localparam int STAT_W    = 2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANK  = 2'd2;
    localparam logic [STAT_W-1:0] ST_LEN   = 2'd3;

    // symbol codes
    localparam logic SYM_A = 1'b0;
    localparam logic SYM_Z = 1'b1;

endpackage

[sv/kth_combination_unrank_top.sv]
// kth_combination_unrank_top: top level of the lexicographic combination unranker
// depends on kcu_pkg, kcu_table and kcu_seq
//
// channel  direction  tdata                                      tuser       tlast
// s        in         zero_count, one_count, rank (from bit 0)   -           -
// m        out        symbol                                     status      last
//
// after reset the table fill sweep runs with o_s_tready low
// an item takes an accept step and a rank check, then one table read per symbol
// error and empty-word items end at the rank check with a single result
// a stalled output holds the sequencer; the next item is taken once the last
// result of the current one is in the output register

module kth_combination_unrank_top import kcu_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // zero_count[6:0], one_count[13:7], rank[43:14]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // symbol[0]
    output logic [STAT_W-1:0]    o_m_tuser,   // status[1:0]
    output logic                 o_m_tlast
);

    localparam int DIM   = MAX_LEN + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(DIM);

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [VAL_W-1:0]  rd_data;
    logic              fill_done;
    logic              symbol;

    // unpack the input transaction
    logic [CNT_W-1:0]  zero_count;
    logic [CNT_W-1:0]  one_count;
    logic [RANK_W-1:0] rank;

    assign zero_count = i_s_tdata[CNT_W-1:0];
    assign one_count  = i_s_tdata[2*CNT_W-1:CNT_W];
    assign rank       = i_s_tdata[2*CNT_W+RANK_W-1:2*CNT_W];

    kcu_table #(
        .MAX_LEN (MAX_LEN),
        .DIM     (DIM),
        .DEPTH   (DEPTH),
        .AW      (AW),
        .RW      (RW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_fill_done (fill_done)
    );

    kcu_seq #(
        .MAX_LEN (MAX_LEN),
        .DIM     (DIM),
        .DEPTH   (DEPTH),
        .AW      (AW),
        .RW      (RW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_done  (fill_done),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_zero_count (zero_count),
        .i_one_count  (one_count),
        .i_rank       (rank),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_symbol     (symbol),
        .o_status     (o_m_tuser),
        .o_last       (o_m_tlast)
    );

    // pack the result transaction
    assign o_m_tdata = {{(M_TDATA_W-1){1'b0}}, symbol};

endmodule

[sv/kcu_table.sv]
// kcu_table: binomial coefficient memory with a row-by-row fill sweep after reset
// depends on kcu_pkg; one write port, one read port with registered read data

module kcu_table import kcu_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int DIM     = MAX_LEN + 1,
    parameter int DEPTH   = DIM * DIM,
    parameter int AW      = $clog2(DEPTH),
    parameter int RW      = $clog2(DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [VAL_W-1:0] o_rd_data,
    output logic             o_fill_done
);

    logic [VAL_W-1:0] mem [DEPTH];

    // fill sweep counters
    logic          r_filling;
    logic [RW-1:0] r_row;
    logic [RW-1:0] r_col;
    logic [AW-1:0] r_waddr;

    // write stage, in the cycle after the read of the row above
    logic          r_wr_valid;
    logic [AW-1:0] r_wr_addr;
    logic          r_wr_row0;
    logic          r_wr_col0;
    logic [VAL_W-1:0] r_left;
    logic [VAL_W-1:0] r_rd_data;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W:0]   sum;
    logic [VAL_W-1:0] wr_data;
    logic             last_entry;

    // read port is owned by the fill sweep until it finishes; row 0 has no row above
    always_comb begin
        if (r_filling) begin
            rd_en   = (r_row != '0);
            rd_addr = r_waddr - AW'(DIM);
        end else begin
            rd_en   = i_rd_en;
            rd_addr = i_rd_addr;
        end
    end

    // pascal rule with saturation: up is the entry above, left the one above-left
    assign sum = {1'b0, r_rd_data} + {1'b0, r_left};

    always_comb begin
        if (r_wr_col0) begin
            wr_data = VAL_W'(1);
        end else if (r_wr_row0) begin
            wr_data = '0;
        end else if (sum > {1'b0, BINOM_CAP}) begin
            wr_data = BINOM_CAP;
        end else begin
            wr_data = sum[VAL_W-1:0];
        end
    end

    assign last_entry = (r_row == RW'(MAX_LEN)) && (r_col == RW'(MAX_LEN));

    // memory
    always_ff @(posedge i_clk) begin
        if (r_wr_valid) begin
            mem[r_wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling  <= 1'b1;
            r_row      <= '0;
            r_col      <= '0;
            r_waddr    <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= r_filling;
            if (r_filling) begin
                r_waddr <= r_waddr + AW'(1);
                if (r_col == RW'(MAX_LEN)) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + RW'(1);
                end
                if (last_entry) begin
                    r_filling <= 1'b0;
                end
            end
        end
    end

    // write stage payload
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_waddr;
        r_wr_row0 <= (r_row == '0);
        r_wr_col0 <= (r_col == '0);
        if (r_wr_valid) begin
            r_left <= r_rd_data;
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_fill_done = !r_filling && !r_wr_valid;

endmodule

[sv/kcu_seq.sv]
// kcu_seq: per-item sequencer that walks the word one symbol per table read
// depends on kcu_pkg; drives the read port of kcu_table and the result register

module kcu_seq import kcu_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int DIM     = MAX_LEN + 1,
    parameter int DEPTH   = DIM * DIM,
    parameter int AW      = $clog2(DEPTH),
    parameter int RW      = $clog2(DIM)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fill_done,
    // input transaction
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CNT_W-1:0]  i_zero_count,
    input  logic [CNT_W-1:0]  i_one_count,
    input  logic [RANK_W-1:0] i_rank,
    // table read port
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [VAL_W-1:0]  i_rd_data,
    // result transaction
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_symbol,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_SYM  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [RW-1:0]     r_zeros, n_zeros;
    logic [RW-1:0]     r_ones, n_ones;
    logic [RW-1:0]     r_len, n_len;
    logic [RW-1:0]     r_left, n_left;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              r_len_err, n_len_err;

    logic              r_out_valid, n_out_valid;
    logic              r_out_sym, n_out_sym;
    logic [STAT_W-1:0] r_out_stat, n_out_stat;
    logic              r_out_last, n_out_last;

    logic              out_free;
    logic              accept;
    logic [CNT_W:0]    in_len;
    logic              take_a;
    logic [RW:0]       rem_next;

    // table address of row r, column c
    function automatic logic [AW-1:0] tbl_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
        tbl_addr = AW'(r) * AW'(DIM) + AW'(c);
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && i_fill_done;
    assign accept     = i_in_valid && o_in_ready;
    assign in_len     = {1'b0, i_zero_count} + {1'b0, i_one_count};

    // symbol decision on the count of completions that start with 'a'
    assign take_a = (r_zeros != '0) && (i_rd_data >= r_rank);

    always_comb begin
        n_state     = r_state;
        n_zeros     = r_zeros;
        n_ones      = r_ones;
        n_len       = r_len;
        n_left      = r_left;
        n_rank      = r_rank;
        n_len_err   = r_len_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sym   = r_out_sym;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        rem_next    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_zeros   = RW'(i_zero_count);
                    n_ones    = RW'(i_one_count);
                    n_len     = RW'(in_len);
                    n_left    = RW'(in_len);
                    n_rank    = i_rank;
                    n_len_err = (in_len > (CNT_W+1)'(MAX_LEN));
                    // total count of words with these symbol counts
                    o_rd_en   = !n_len_err;
                    o_rd_addr = tbl_addr(RW'(in_len), RW'(i_zero_count));
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (out_free) begin
                    if (r_len_err || (i_rd_data < r_rank) || (r_len == '0)) begin
                        n_out_valid = 1'b1;
                        n_out_sym   = SYM_A;
                        n_out_last  = 1'b1;
                        if (r_len_err) begin
                            n_out_stat = ST_LEN;
                        end else if (i_rd_data < r_rank) begin
                            n_out_stat = ST_RANK;
                        end else begin
                            n_out_stat = ST_EMPTY;
                        end
                        n_state = S_IDLE;
                    end else begin
                        rem_next  = {1'b0, r_zeros} + {1'b0, r_ones} - (RW+1)'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = tbl_addr(RW'(rem_next), r_ones);
                        n_state   = S_SYM;
                    end
                end
            end
            S_SYM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = ST_OK;
                    n_out_last  = (r_left == RW'(1));
                    if (take_a) begin
                        n_out_sym = SYM_A;
                        n_zeros   = r_zeros - RW'(1);
                    end else begin
                        n_out_sym = SYM_Z;
                        n_rank    = (i_rd_data <= r_rank) ? (r_rank - i_rd_data) : '0;
                        if (r_ones != '0) begin
                            n_ones = r_ones - RW'(1);
                        end
                    end
                    n_left = r_left - RW'(1);
                    if (r_left == RW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch completions for the next position
                        rem_next  = {1'b0, n_zeros} + {1'b0, n_ones} - (RW+1)'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = tbl_addr(RW'(rem_next), n_ones);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_zeros    <= n_zeros;
        r_ones     <= n_ones;
        r_len      <= n_len;
        r_left     <= n_left;
        r_rank     <= n_rank;
        r_len_err  <= n_len_err;
        r_out_sym  <= n_out_sym;
        r_out_stat <= n_out_stat;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_sym;
    assign o_status    = r_out_stat;
    assign o_last      = r_out_last;

endmodule
